### rtl/tpjb_pkg.sv
package tpjb_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int HANDLE_BITS_DEFAULT = 16;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED    = 3'd0,
		ST_FULL_DROP   = 3'd1,
		ST_PLAYED      = 3'd2,
		ST_UNDERRUN    = 3'd3,
		ST_NOT_STARTED = 3'd4,
		ST_CLEARED     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WSCAN,
		S_WRITE,
		S_CLEAR,
		S_RSCAN,
		S_RDONE,
		S_DSCAN,
		S_OUT
	} state_t;

	localparam logic [0:0] REG_STREAM_MODE   = 1'b0;
	localparam logic [0:0] REG_PLAYOUT_DELAY = 1'b1;

endpackage

### rtl/tpjb_if.sv
interface tpjb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] packet_sequence;
	logic [31:0] packet_timestamp;
	logic [15:0] payload_handle;
	logic [62:0] now_time;
	modport source (output valid, command, packet_sequence, packet_timestamp,
		payload_handle, now_time, input ready);
	modport sink (input valid, command, packet_sequence, packet_timestamp,
		payload_handle, now_time, output ready);
endinterface

interface tpjb_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] out_sequence;
	logic [31:0] out_timestamp;
	logic [15:0] out_payload;
	logic [6:0]  fill_level;
	logic [5:0]  late_dropped_now;
	logic [31:0] received_total;
	logic [31:0] overflow_total;
	logic [31:0] underrun_total;
	logic [31:0] played_total;
	logic [31:0] late_total;
	modport source (output valid, status, out_sequence, out_timestamp, out_payload,
		fill_level, late_dropped_now, received_total, overflow_total, underrun_total,
		played_total, late_total, input ready);
	modport sink (input valid, status, out_sequence, out_timestamp, out_payload,
		fill_level, late_dropped_now, received_total, overflow_total, underrun_total,
		played_total, late_total, output ready);
endinterface

### rtl/tpjb_ram.sv
module tpjb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/timed_playout_jitter_buffer.sv
// timed playout jitter buffer
// in channel: command with packet fields; insert (0), read at now_time (1),
// clear (2); command 3 is taken and dropped with no result.
// out channel: one result per insert, read or clear, with status, the
// played descriptor, fill level and the running counters.
// an insert walks the valid bits from the write pointer to a free slot,
// or drops the packet when the buffer is full. a read sweeps the
// descriptor memory once to find the lowest eligible sequence and, when a
// packet plays, again to drop lower ones; an underrun answers after the
// first sweep. each sweep goes slot by slot through the single read port.
// a clear or a read before the first insert answers in the cycle after the
// transfer. the items are handled one at a time.
// reset empties the buffer, zeroes counters, sets sync mode and a zero
// playout delay. the result stays in an output register until taken; the
// next item is accepted only after the result has been transferred.
// configuration goes through the apb port (mode at 0x0, delay at 0x4).
module timed_playout_jitter_buffer #(
	parameter int DEPTH = tpjb_pkg::DEPTH_DEFAULT,
	parameter int HANDLE_BITS = tpjb_pkg::HANDLE_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tpjb_in_if.sink     in_ch,
	tpjb_out_if.source  out_ch
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
	localparam int MW = 64 + HW;

	logic        mode_q;
	logic [31:0] delay_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			delay_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == tpjb_pkg::REG_STREAM_MODE) begin
				mode_q <= pwdata[0];
			end else begin
				delay_q <= pwdata;
			end
		end
	end
	always_comb begin
		prdata = (paddr[2] == tpjb_pkg::REG_STREAM_MODE) ? {31'd0, mode_q} : delay_q;
	end

	tpjb_pkg::state_t state_q, state_d;
	logic [DEPTH-1:0] valid_q;
	logic [AW-1:0]    wp_q, idx_q, best_q;
	logic [CW-1:0]    cnt_q, fill_q;
	logic             started_q, found_q, rd_v_s1;
	logic [AW-1:0]    rd_idx_s1;
	logic [31:0]      best_seq_q;
	logic [31:0]      c_rx_q, c_ov_q, c_un_q, c_pl_q, c_lt_q;
	logic [31:0]      seq_q, ts_q;
	logic [15:0]      hdl_q;
	logic [62:0]      now_q;
	logic [CW-1:0]    late_q;
	logic             ov_q;

	logic          we;
	logic [AW-1:0] raddr;
	logic [MW-1:0] rdata;
	logic [31:0]   r_seq, r_ts;
	logic [HW-1:0] r_hdl;

	logic          found_n;
	logic [AW-1:0] best_n;
	logic [31:0]   bseq_n;

	tpjb_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_q),
		.wdata ({seq_q, ts_q, hdl_q[HW-1:0]}),
		.raddr (raddr),
		.rdata (rdata)
	);
	assign r_seq = rdata[MW-1 -: 32];
	assign r_ts  = rdata[HW +: 32];
	assign r_hdl = rdata[HW-1:0];

	logic due, elig, last;
	assign due  = (now_q[62:33] != '0)
		|| (({1'b0, r_ts} + {1'b0, delay_q}) <= now_q[32:0]);
	assign elig = valid_q[rd_idx_s1] && (!mode_q || due);
	assign last = (idx_q == AW'(DEPTH - 1));

	assign in_ch.ready = (state_q == tpjb_pkg::S_IDLE) && !out_ch.valid;
	assign we = (state_q == tpjb_pkg::S_WRITE) && !ov_q;
	assign raddr = (state_q == tpjb_pkg::S_RDONE) ? best_n : idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tpjb_pkg::S_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					case (tpjb_pkg::cmd_t'(in_ch.command))
						tpjb_pkg::CMD_INSERT: state_d = tpjb_pkg::S_WSCAN;
						tpjb_pkg::CMD_READ:   state_d = started_q ? tpjb_pkg::S_RSCAN
							: tpjb_pkg::S_CLEAR;
						tpjb_pkg::CMD_CLEAR:  state_d = tpjb_pkg::S_CLEAR;
						default:              state_d = tpjb_pkg::S_IDLE;
					endcase
				end
			end
			tpjb_pkg::S_WSCAN: begin
				if (cnt_q >= CW'(DEPTH) || !valid_q[idx_q]) state_d = tpjb_pkg::S_WRITE;
			end
			tpjb_pkg::S_WRITE: state_d = tpjb_pkg::S_IDLE;
			tpjb_pkg::S_CLEAR: state_d = tpjb_pkg::S_IDLE;
			tpjb_pkg::S_RSCAN: if (last) state_d = tpjb_pkg::S_RDONE;
			tpjb_pkg::S_RDONE: state_d = found_q || elig ? tpjb_pkg::S_DSCAN : tpjb_pkg::S_IDLE;
			tpjb_pkg::S_DSCAN: if (last) state_d = tpjb_pkg::S_OUT;
			tpjb_pkg::S_OUT: state_d = tpjb_pkg::S_IDLE;
			default: state_d = tpjb_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		found_n = found_q;
		best_n  = best_q;
		bseq_n  = best_seq_q;
		if (rd_v_s1 && elig && (!found_q || r_seq < best_seq_q)) begin
			found_n = 1'b1;
			best_n  = rd_idx_s1;
			bseq_n  = r_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tpjb_pkg::S_IDLE;
			valid_q   <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			cnt_q     <= '0;
			started_q <= 1'b0;
			c_rx_q <= '0; c_ov_q <= '0; c_un_q <= '0; c_pl_q <= '0; c_lt_q <= '0;
			out_ch.valid <= 1'b0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			rd_v_s1 <= (state_q == tpjb_pkg::S_RSCAN) || (state_q == tpjb_pkg::S_DSCAN);
			case (state_q)
				tpjb_pkg::S_IDLE: begin
					idx_q <= (in_ch.valid && in_ch.ready
						&& in_ch.command == tpjb_pkg::CMD_INSERT) ? wp_q : '0;
					found_q <= 1'b0;
					late_q <= '0;
					if (in_ch.valid && in_ch.ready) begin
						seq_q <= in_ch.packet_sequence;
						ts_q  <= in_ch.packet_timestamp;
						hdl_q <= in_ch.payload_handle;
						now_q <= in_ch.now_time;
						case (tpjb_pkg::cmd_t'(in_ch.command))
							tpjb_pkg::CMD_INSERT: begin
								started_q <= 1'b1;
								c_rx_q <= c_rx_q + 32'd1;
								cnt_q <= fill_q;
							end
							tpjb_pkg::CMD_READ: begin
								if (!started_q) begin
									out_ch.valid <= 1'b1;
									out_ch.status <= tpjb_pkg::ST_NOT_STARTED;
									out_ch.out_sequence <= '0;
									out_ch.out_timestamp <= '0;
									out_ch.out_payload <= '0;
									out_ch.fill_level <= 7'(fill_q);
									out_ch.late_dropped_now <= '0;
								end
							end
							tpjb_pkg::CMD_CLEAR: begin
								valid_q <= '0; wp_q <= '0; fill_q <= '0; started_q <= 1'b0;
								c_rx_q <= '0; c_ov_q <= '0; c_un_q <= '0;
								c_pl_q <= '0; c_lt_q <= '0;
								out_ch.valid <= 1'b1;
								out_ch.status <= tpjb_pkg::ST_CLEARED;
								out_ch.out_sequence <= '0;
								out_ch.out_timestamp <= '0;
								out_ch.out_payload <= '0;
								out_ch.fill_level <= '0;
								out_ch.late_dropped_now <= '0;
							end
							default: ;
						endcase
					end
				end
				tpjb_pkg::S_WSCAN: begin
					ov_q <= cnt_q >= CW'(DEPTH);
					if (cnt_q < CW'(DEPTH) && valid_q[idx_q]) begin
						idx_q <= (idx_q == AW'(DEPTH - 1)) ? '0 : idx_q + AW'(1);
					end
				end
				tpjb_pkg::S_WRITE: ;
				tpjb_pkg::S_RSCAN: begin
					rd_idx_s1 <= idx_q;
					idx_q <= last ? '0 : idx_q + AW'(1);
					found_q <= found_n; best_q <= best_n; best_seq_q <= bseq_n;
				end
				tpjb_pkg::S_RDONE: begin
					found_q <= found_n; best_q <= best_n; best_seq_q <= bseq_n;
					if (!found_n) begin
						c_un_q <= c_un_q + 32'd1;
						out_ch.valid <= 1'b1;
						out_ch.status <= tpjb_pkg::ST_UNDERRUN;
						out_ch.out_sequence <= '0;
						out_ch.out_timestamp <= '0;
						out_ch.out_payload <= '0;
						out_ch.fill_level <= 7'(fill_q);
						out_ch.late_dropped_now <= '0;
						out_ch.underrun_total <= c_un_q + 32'd1;
					end else begin
						valid_q[best_n] <= 1'b0;
					end
				end
				tpjb_pkg::S_DSCAN: begin
					rd_idx_s1 <= idx_q;
					idx_q <= last ? '0 : idx_q + AW'(1);
					if (rd_v_s1 && valid_q[rd_idx_s1] && r_seq < best_seq_q) begin
						valid_q[rd_idx_s1] <= 1'b0;
						late_q <= late_q + CW'(1);
					end
				end
				tpjb_pkg::S_OUT: begin
					begin : fin
						logic [CW-1:0] lt;
						lt = late_q;
						if (rd_v_s1 && valid_q[rd_idx_s1] && r_seq < best_seq_q) begin
							valid_q[rd_idx_s1] <= 1'b0;
							lt = late_q + CW'(1);
						end
						fill_q <= fill_q - CW'(1) - lt;
						c_pl_q <= c_pl_q + 32'd1;
						c_lt_q <= c_lt_q + 32'(lt);
						out_ch.valid <= 1'b1;
						out_ch.status <= tpjb_pkg::ST_PLAYED;
						out_ch.fill_level <= 7'(fill_q - CW'(1) - lt);
						out_ch.late_dropped_now <= 6'(lt);
						out_ch.played_total <= c_pl_q + 32'd1;
						out_ch.late_total <= c_lt_q + 32'(lt);
					end
				end
				default: ;
			endcase
			if (state_q == tpjb_pkg::S_WRITE) begin
				out_ch.valid <= 1'b1;
				out_ch.out_sequence <= '0;
				out_ch.out_timestamp <= '0;
				out_ch.out_payload <= '0;
				out_ch.late_dropped_now <= '0;
				out_ch.received_total <= c_rx_q;
				if (ov_q) begin
					c_ov_q <= c_ov_q + 32'd1;
					out_ch.overflow_total <= c_ov_q + 32'd1;
					out_ch.status <= tpjb_pkg::ST_FULL_DROP;
					out_ch.fill_level <= 7'(fill_q);
				end else begin
					valid_q[idx_q] <= 1'b1;
					wp_q <= (idx_q == AW'(DEPTH - 1)) ? '0 : idx_q + AW'(1);
					fill_q <= fill_q + CW'(1);
					out_ch.status <= tpjb_pkg::ST_ACCEPTED;
					out_ch.fill_level <= 7'(fill_q + CW'(1));
				end
			end
			if (state_q == tpjb_pkg::S_OUT) begin
				out_ch.out_sequence  <= best_seq_q;
				out_ch.out_timestamp <= ts_q;
				out_ch.out_payload   <= 16'(hdl_q);
			end
			if (state_q != tpjb_pkg::S_WRITE && state_q != tpjb_pkg::S_OUT
				&& state_q != tpjb_pkg::S_RDONE) begin
				out_ch.received_total <= (state_q == tpjb_pkg::S_IDLE && in_ch.valid
					&& in_ch.ready && in_ch.command == tpjb_pkg::CMD_CLEAR) ? '0 : c_rx_q;
				out_ch.overflow_total <= (state_q == tpjb_pkg::S_IDLE && in_ch.valid
					&& in_ch.ready && in_ch.command == tpjb_pkg::CMD_CLEAR) ? '0 : c_ov_q;
				out_ch.underrun_total <= (state_q == tpjb_pkg::S_IDLE && in_ch.valid
					&& in_ch.ready && in_ch.command == tpjb_pkg::CMD_CLEAR) ? '0 : c_un_q;
				out_ch.played_total <= (state_q == tpjb_pkg::S_IDLE && in_ch.valid
					&& in_ch.ready && in_ch.command == tpjb_pkg::CMD_CLEAR) ? '0 : c_pl_q;
				out_ch.late_total <= (state_q == tpjb_pkg::S_IDLE && in_ch.valid
					&& in_ch.ready && in_ch.command == tpjb_pkg::CMD_CLEAR) ? '0 : c_lt_q;
			end
			if (state_q == tpjb_pkg::S_DSCAN && idx_q == '0 && !rd_v_s1) begin
				ts_q  <= r_ts;
				hdl_q <= 16'(r_hdl);
			end
		end
	end
endmodule
